>>> rtl/igov_pkg.sv
// Shared types, codes and helpers for the idle-state ladder governor.
// Used by igov_front, igov_back and idle_state_ladder_governor_top.
package igov_pkg;

  // State index width and number of counter slots (indexes 0..7)
  localparam int IDX_W       = 3;
  localparam int STATE_SLOTS = 8;

  // State type codes (code zero is treated as shallow)
  localparam logic [1:0] TYPE_NONE    = 2'd0;
  localparam logic [1:0] TYPE_SHALLOW = 2'd1;
  localparam logic [1:0] TYPE_MEDIUM  = 2'd2;
  localparam logic [1:0] TYPE_DEEP    = 2'd3;

  // Bus-master reload actions
  localparam logic [1:0] RELOAD_NONE    = 2'd0;
  localparam logic [1:0] RELOAD_ENABLE  = 2'd1;
  localparam logic [1:0] RELOAD_DISABLE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_VALID_MASK   = 3'd0;
  localparam logic [2:0] CFG_TYPE_TABLE   = 3'd1;
  localparam logic [2:0] CFG_MEDIUM_LAT   = 3'd2;
  localparam logic [2:0] CFG_DEEP_LAT     = 3'd3;
  localparam logic [2:0] CFG_MAX_STATE    = 3'd4;
  localparam logic [2:0] CFG_HISTORY_MASK = 3'd5;
  localparam logic [2:0] CFG_WIDE_TIMER   = 3'd6;
  localparam logic [2:0] CFG_BM_CHECK     = 3'd7;

  // Reset values of the registers
  localparam logic [7:0]  VALID_MASK_RESET   = 8'd2;
  localparam logic [3:0]  MAX_STATE_RESET    = 4'd8;
  localparam logic [31:0] HISTORY_MASK_RESET = 32'hFFFF_FFFF;

  // Tick saturation and promotion thresholds
  localparam logic [5:0] TICKS_MAX       = 6'd32;
  localparam logic [7:0] NEED_DEEPER     = 8'd4;
  localparam logic [7:0] NEED_SHALLOW    = 8'd10;
  localparam logic [7:0] COUNT_MAX       = 8'd255;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [7:0]  valid_mask;
    logic [13:0] type_table;
    logic [11:0] medium_lat;
    logic [11:0] deep_lat;
    logic [3:0]  max_state;
    logic [31:0] history_mask;
    logic        wide_timer;
    logic        bm_check_on;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [31:0] elapsed;
    logic        bm_seen;
    logic [5:0]  ticks;
  } item_t;

  // Result item, next_index in the lowest bits
  typedef struct packed {
    logic       clear_status;
    logic [1:0] reload_action;
    logic       slept;
    logic       changed;
    idx_t       next_index;
  } result_t;

  // Type of state i (1..7); index zero and type zero count as shallow
  function automatic logic [1:0] type_of(logic [13:0] tt, idx_t i);
    logic [3:0] pos;
    logic [1:0] t;
    pos = {i - 3'd1, 1'b0};
    t   = tt[pos +: 2];
    if (i == '0 || t == TYPE_NONE) begin
      return TYPE_SHALLOW;
    end
    return t;
  endfunction

endpackage

>>> rtl/igov_front.sv
// Front end of the idle-state ladder governor: accepts episodes, saturates
// the tick count, measures the timer interval and queues the item.
// Depends on igov_pkg.
module igov_front
  import igov_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_ticks,
  input  logic        in_bm_seen,
  input  logic [31:0] in_start,
  input  logic [31:0] in_end,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       item_in;
  logic [31:0] diff;
  logic [31:0] diff_m1;
  logic        no_wrap;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Classify: saturate ticks, unwrap the timer interval
  always_comb begin
    no_wrap = (in_end >= in_start);
    diff    = in_end - in_start;
    diff_m1 = in_end + ~in_start;
    item_in.ticks   = (in_ticks > TICKS_MAX) ? TICKS_MAX : in_ticks;
    item_in.bm_seen = in_bm_seen;
    if (no_wrap) begin
      item_in.elapsed = diff;
    end else if (cfg.wide_timer) begin
      item_in.elapsed = diff_m1;
    end else begin
      item_in.elapsed = {8'h00, diff_m1[23:0]};
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/igov_back.sv
// Back end of the idle-state ladder governor: bus-master history, ladder
// links, promotion and demotion counters, output register.
// Depends on igov_pkg.
module igov_back
  import igov_pkg::*;
#(
  parameter int NUM_STATES     = 8,
  parameter int SLEEP_OVERHEAD = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_mask_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  typedef enum logic {S_EVAL, S_DECIDE} state_t;

  localparam logic [31:0] OVERHEAD = 32'(SLEEP_OVERHEAD);

  state_t      state;
  idx_t        current_index;
  logic [31:0] busy_hist;
  logic [7:0]  promote_counts [STATE_SLOTS];
  logic [7:0]  demote_counts  [STATE_SLOTS];
  logic [31:0] hist_eval;
  logic [31:0] rem_eval;
  logic        bm_eval;

  // Lowest valid index of a mask, zero if none
  function automatic idx_t lowest_valid(logic [7:0] mask);
    idx_t res;
    res = '0;
    for (int i = 1; i < STATE_SLOTS; i++) begin
      if (i < NUM_STATES && mask[i] && res == '0) begin
        res = IDX_W'(i);
      end
    end
    return res;
  endfunction

  // Lowest valid index above i
  function automatic idx_t up_link(logic [7:0] mask, idx_t i);
    idx_t res;
    res = '0;
    for (int j = 1; j < STATE_SLOTS; j++) begin
      if (IDX_W'(j) > i && j < NUM_STATES && mask[j] && res == '0) begin
        res = IDX_W'(j);
      end
    end
    return res;
  endfunction

  // Highest valid index below i
  function automatic idx_t down_link(logic [7:0] mask, idx_t i);
    idx_t res;
    res = '0;
    for (int j = STATE_SLOTS - 1; j >= 1; j--) begin
      if (IDX_W'(j) < i && j < NUM_STATES && mask[j] && res == '0) begin
        res = IDX_W'(j);
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

  function automatic logic [11:0] latency(cfg_t c, logic [1:0] t);
    if (t == TYPE_MEDIUM) begin
      return c.medium_lat;
    end else if (t == TYPE_DEEP) begin
      return c.deep_lat;
    end
    return 12'd0;
  endfunction

  // Evaluate: fold ticks and activity into history, subtract latency
  logic [31:0] fill_ones;
  logic [31:0] hist_tick;
  logic [31:0] hist_new;
  logic [1:0]  cur_type;
  logic [11:0] cur_lat;
  logic [31:0] rem_new;

  always_comb begin
    cur_type = type_of(cfg.type_table, current_index);
    cur_lat  = latency(cfg, cur_type);
    for (int b = 0; b < 32; b++) begin
      fill_ones[b] = (b >= 2) && (6'(b) <= q_item.ticks);
    end
    hist_tick = (busy_hist << q_item.ticks) | fill_ones;
    hist_new  = q_item.bm_seen ? hist_tick + 32'd1 : hist_tick;
    rem_new   = q_item.elapsed - ({20'd0, cur_lat} + OVERHEAD);
  end

  // Decide: ladder step, counters, reload action
  idx_t        up;
  idx_t        dn;
  logic        hit;
  logic        early;
  logic        shallow_cur;
  logic        sleep_long;
  logic        sleep_short;
  logic        long_path;
  logic        short_path;
  logic        promote_go;
  logic        blocked;
  logic [7:0]  pc_sat;
  logic [7:0]  dc_sat;
  logic [7:0]  need;
  idx_t        nxt_step;
  idx_t        nxt;
  logic        changed;
  logic        old_deep;
  logic        new_deep;
  logic        commit;
  result_t     res;

  always_comb begin
    up          = up_link(cfg.valid_mask, current_index);
    dn          = down_link(cfg.valid_mask, current_index);
    hit         = (hist_eval & cfg.history_mask) != 32'd0;
    shallow_cur = (cur_type == TYPE_SHALLOW);
    early       = cfg.bm_check_on && (cur_type == TYPE_DEEP) && dn != '0 && hit;
    sleep_long  = shallow_cur || ($signed(rem_eval) > $signed({20'd0, cur_lat}));
    sleep_short = !shallow_cur && ($signed(rem_eval) < $signed({20'd0, cur_lat}));
    pc_sat      = sat_inc(promote_counts[current_index]);
    dc_sat      = sat_inc(demote_counts[current_index]);
    need        = shallow_cur ? NEED_SHALLOW : NEED_DEEPER;
    blocked     = cfg.bm_check_on && (type_of(cfg.type_table, up) == TYPE_DEEP) && hit;
    long_path   = !early && up != '0 && ({1'b0, up} <= cfg.max_state) && sleep_long;
    promote_go  = long_path && (pc_sat >= need) && !blocked;
    short_path  = !early && !long_path && dn != '0 && sleep_short;

    if (early) begin
      nxt_step = dn;
    end else if (promote_go) begin
      nxt_step = up;
    end else if (short_path) begin
      nxt_step = dn;
    end else begin
      nxt_step = current_index;
    end
    // Clamp to the deepest allowed state
    nxt      = ({1'b0, current_index} > cfg.max_state && dn != '0) ? dn : nxt_step;
    changed  = (nxt != current_index);
    old_deep = (cur_type == TYPE_DEEP);
    new_deep = (type_of(cfg.type_table, nxt) == TYPE_DEEP);

    res.next_index    = nxt;
    res.changed       = changed;
    res.slept         = !early;
    res.clear_status  = cfg.bm_check_on && bm_eval;
    res.reload_action = RELOAD_NONE;
    if (changed && old_deep && !new_deep) begin
      res.reload_action = RELOAD_DISABLE;
    end else if (changed && new_deep && !old_deep) begin
      res.reload_action = RELOAD_ENABLE;
    end
    if (current_index == '0) begin
      res.next_index    = '0;
      res.changed       = 1'b0;
      res.slept         = 1'b1;
      res.reload_action = RELOAD_NONE;
      res.clear_status  = 1'b0;
    end
  end

  assign commit = (state == S_DECIDE) && (!out_valid || out_ready);
  assign q_pop  = (state == S_EVAL) && q_valid;

  // Hold evaluated values between the two steps
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hist_eval <= hist_new;
      rem_eval  <= rem_new;
      bm_eval   <= q_item.bm_seen;
    end
    if (commit) begin
      out_result <= res;
    end
  end

  // Sequence steps, hold governor state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_EVAL;
      out_valid     <= 1'b0;
      current_index <= lowest_valid(VALID_MASK_RESET);
      busy_hist     <= '0;
      for (int k = 0; k < STATE_SLOTS; k++) begin
        promote_counts[k] <= '0;
        demote_counts[k]  <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_EVAL: begin
          if (q_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (commit) begin
            out_valid <= 1'b1;
            state     <= S_EVAL;
            if (current_index != '0) begin
              if (cfg.bm_check_on) begin
                busy_hist <= hist_eval;
              end
              if (long_path) begin
                promote_counts[current_index] <= pc_sat;
                demote_counts[current_index]  <= '0;
              end else if (short_path) begin
                demote_counts[current_index]  <= dc_sat;
                promote_counts[current_index] <= '0;
              end
              if (changed) begin
                promote_counts[current_index] <= '0;
                demote_counts[nxt]            <= '0;
                current_index                 <= nxt;
              end
            end
          end
        end
        default: state <= S_EVAL;
      endcase
      // Rebuild the ladder on a mask or type write
      if (cfg_we && (cfg_index == CFG_VALID_MASK || cfg_index == CFG_TYPE_TABLE)) begin
        current_index <= (cfg_index == CFG_VALID_MASK) ? lowest_valid(cfg_mask_data)
                                                       : lowest_valid(cfg.valid_mask);
        for (int k = 0; k < STATE_SLOTS; k++) begin
          promote_counts[k] <= '0;
          demote_counts[k]  <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/idle_state_ladder_governor_top.sv
// Top level of the idle-state ladder governor: configuration registers,
// front end (classify and queue) and back end (ladder decision).
// Depends on igov_pkg, igov_front and igov_back.
//
// Usage: each idle episode enters as one transaction on the s_ channel and
// yields exactly one result transaction on the m_ channel, in order.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// while no episode is in flight; writing the valid mask or the type table
// restarts the ladder at the lowest valid state and clears the counters.
// An accepted episode is queued at the accepting edge; the back end's
// evaluate step pops it and registers its history and remaining sleep,
// and its decide step then registers the result in the output register;
// both steps read and update the ladder state, so the back end takes no
// new episode before the last one is decided. A two-entry queue parts
// the front from the back, and the output register holds a result while
// the receiver stalls; the back stops once it has a result it cannot
// hand over, and the front keeps taking episodes until the queue is full.
// Reset (rst, synchronous): registers take their reset values, the current
// state goes to the lowest valid index, history and counters clear.
module idle_state_ladder_governor_top
  import igov_pkg::*;
#(
  parameter int NUM_STATES     = 8,
  parameter int SLEEP_OVERHEAD = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // elapsed_ticks[5:0], bm_seen[6], start_time[38:7], end_time[70:39], pad[71]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_index[2:0], changed[3], slept[4], reload_action[6:5], clear_status[7]
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t result;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_mask   <= VALID_MASK_RESET;
      cfg.type_table   <= '0;
      cfg.medium_lat   <= '0;
      cfg.deep_lat     <= '0;
      cfg.max_state    <= MAX_STATE_RESET;
      cfg.history_mask <= HISTORY_MASK_RESET;
      cfg.wide_timer   <= 1'b0;
      cfg.bm_check_on  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VALID_MASK:   cfg.valid_mask   <= cfg_data[7:0];
        CFG_TYPE_TABLE:   cfg.type_table   <= cfg_data[13:0];
        CFG_MEDIUM_LAT:   cfg.medium_lat   <= cfg_data[11:0];
        CFG_DEEP_LAT:     cfg.deep_lat     <= cfg_data[11:0];
        CFG_MAX_STATE:    cfg.max_state    <= cfg_data[3:0];
        CFG_HISTORY_MASK: cfg.history_mask <= cfg_data;
        CFG_WIDE_TIMER:   cfg.wide_timer   <= cfg_data[0];
        CFG_BM_CHECK:     cfg.bm_check_on  <= cfg_data[0];
        default:          cfg.bm_check_on  <= cfg.bm_check_on;
      endcase
    end
  end

  igov_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_ticks   (s_tdata[5:0]),
    .in_bm_seen (s_tdata[6]),
    .in_start   (s_tdata[38:7]),
    .in_end     (s_tdata[70:39]),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  igov_back #(
    .NUM_STATES     (NUM_STATES),
    .SLEEP_OVERHEAD (SLEEP_OVERHEAD)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_mask_data (cfg_data[7:0]),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_result    (result)
  );

  assign m_tdata = result;

endmodule

>>> bench/idle_state_ladder_governor_top_tb.sv
// Self-checking testbench for idle_state_ladder_governor_top: directed and random idle
// episodes under many ladder settings, checked against a cycle-free model of the ladder.
// Depends on igov_pkg and the governor RTL.
module idle_state_ladder_governor_top_tb;
  import igov_pkg::*;

  localparam int NUM_ST   = 8;
  localparam int OVERHEAD = 4;

  typedef struct packed {
    logic [31:0] t_end;
    logic [31:0] t_start;
    logic        bm;
    logic [5:0]  ticks;
  } episode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // elapsed_ticks[5:0], bm_seen[6], start_time[38:7], end_time[70:39], pad[71]
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // next_index[2:0], changed[3], slept[4], reload_action[6:5], clear_status[7]
  logic [7:0]  m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  idle_state_ladder_governor_top #(
    .NUM_STATES    (NUM_ST),
    .SLEEP_OVERHEAD(OVERHEAD)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Model copy of the registers and the ladder state
  logic [7:0]  reg_valid;
  logic [13:0] reg_types;
  logic [11:0] reg_med_lat;
  logic [11:0] reg_deep_lat;
  logic [3:0]  reg_max;
  logic [31:0] reg_hmask;
  logic        reg_wide;
  logic        reg_bm_on;
  logic [2:0]  cur_idx;
  logic [31:0] busy_hist;
  logic [7:0]  promote_tally [NUM_ST];
  logic [7:0]  demote_tally [NUM_ST];

  episode_t episode_queue [$];
  result_t  predicted_moves [$];
  episode_t on_offer;
  int episodes_queued = 0;
  int episodes_sent = 0;
  int decisions_checked = 0;
  int errors = 0;
  int settings_count = 0;
  int state_moves = 0;
  int early_demotions = 0;

  function automatic bit usable(int i);
    return i >= 1 && i < NUM_ST && i < 8 && reg_valid[i];
  endfunction

  function automatic logic [1:0] kind_of(int i);
    logic [1:0] t;
    if (i < 1 || i > 7) return TYPE_SHALLOW;
    t = reg_types[2*(i-1) +: 2];
    return (t == TYPE_NONE) ? TYPE_SHALLOW : t;
  endfunction

  function automatic int exit_latency(int i);
    if (kind_of(i) == TYPE_MEDIUM) return int'(reg_med_lat);
    if (kind_of(i) == TYPE_DEEP) return int'(reg_deep_lat);
    return 0;
  endfunction

  function automatic logic [2:0] rung_above(int i);
    for (int j = i + 1; j < NUM_ST && j < 8; j++)
      if (usable(j)) return 3'(j);
    return '0;
  endfunction

  function automatic logic [2:0] rung_below(int i);
    for (int j = i - 1; j >= 1; j--)
      if (usable(j)) return 3'(j);
    return '0;
  endfunction

  // Restart at the lowest usable rung with cleared counters
  function automatic void restart_ladder();
    for (int i = 0; i < NUM_ST; i++) begin
      promote_tally[i] = '0;
      demote_tally[i] = '0;
    end
    cur_idx = rung_above(0);
  endfunction

  // Decide the next rung for one idle episode and update the model state
  function automatic result_t govern_episode(episode_t ep);
    result_t     res;
    logic [2:0]  cur, nxt, up, dn;
    logic [31:0] span, rem;
    logic [7:0]  need;
    int          lat, sleep_len, d;
    bit          done, blocked;
    res = '0;
    res.slept = 1'b1;
    cur = cur_idx;
    if (cur == '0) return res;
    nxt = cur;
    up = rung_above(cur);
    dn = rung_below(cur);
    lat = exit_latency(cur);
    done = 1'b0;
    // Fold ticks and bus-master activity into the history
    if (reg_bm_on) begin
      d = (ep.ticks > TICKS_MAX) ? int'(TICKS_MAX) : int'(ep.ticks);
      while (d > 0) begin
        d--;
        if (d != 0) busy_hist[0] = 1'b1;
        busy_hist = busy_hist << 1;
      end
      if (ep.bm) begin
        busy_hist = busy_hist + 32'd1;
        res.clear_status = 1'b1;
      end
      if (kind_of(cur) == TYPE_DEEP && dn != '0 && (busy_hist & reg_hmask) != '0) begin
        nxt = dn;
        res.slept = 1'b0;
        done = 1'b1;
        early_demotions++;
      end
    end
    if (!done) begin
      // Measure the sleep; shallow rungs count as long
      if (kind_of(cur) == TYPE_SHALLOW) begin
        sleep_len = 32'h7FFF_FFFF;
      end else begin
        if (ep.t_end >= ep.t_start) span = ep.t_end - ep.t_start;
        else if (!reg_wide) span = ((32'h00FF_FFFF - ep.t_start) + ep.t_end) & 32'h00FF_FFFF;
        else span = (32'hFFFF_FFFF - ep.t_start) + ep.t_end;
        rem = span - 32'(lat) - 32'(OVERHEAD);
        sleep_len = rem;
      end
      if (up != '0 && {1'b0, up} <= reg_max && sleep_len > lat) begin
        need = (kind_of(cur) >= TYPE_MEDIUM) ? NEED_DEEPER : NEED_SHALLOW;
        if (promote_tally[cur] < COUNT_MAX) promote_tally[cur]++;
        demote_tally[cur] = '0;
        blocked = reg_bm_on && kind_of(up) == TYPE_DEEP && (busy_hist & reg_hmask) != '0;
        if (promote_tally[cur] >= need && !blocked) begin
          nxt = up;
          done = 1'b1;
        end
      end
      if (!done && dn != '0 && sleep_len < lat) begin
        if (demote_tally[cur] < COUNT_MAX) demote_tally[cur]++;
        promote_tally[cur] = '0;
        nxt = dn;
      end
    end
    // Clamp to the deepest allowed rung
    if ({1'b0, cur} > reg_max && dn != '0) nxt = dn;
    if (nxt != cur) begin
      promote_tally[cur] = '0;
      demote_tally[nxt] = '0;
      if (kind_of(cur) == TYPE_DEEP && kind_of(nxt) != TYPE_DEEP)
        res.reload_action = RELOAD_DISABLE;
      else if (kind_of(nxt) == TYPE_DEEP && kind_of(cur) != TYPE_DEEP)
        res.reload_action = RELOAD_ENABLE;
      cur_idx = nxt;
      state_moves++;
    end
    res.next_index = nxt;
    res.changed = (nxt != cur);
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic episode_t episode_of(int ticks, bit bm, logic [31:0] ts, logic [31:0] te);
    episode_t ep;
    ep.ticks = 6'(ticks);
    ep.bm = bm;
    ep.t_start = ts;
    ep.t_end = te;
    return ep;
  endfunction

  // Random episode, timed mostly around the configured latencies
  function automatic episode_t random_episode();
    episode_t    ep;
    int          r, lat;
    logic [31:0] delta, span;
    r = $urandom_range(0, 99);
    if (r < 40) ep.ticks = 6'd0;
    else if (r < 70) ep.ticks = 6'd1;
    else if (r < 90) ep.ticks = 6'($urandom_range(2, 32));
    else ep.ticks = 6'($urandom_range(33, 63));
    ep.bm = ($urandom_range(0, 99) < 15);
    lat = $urandom_range(0, 1) ? int'(reg_med_lat) : int'(reg_deep_lat);
    span = reg_wide ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
    ep.t_start = $urandom & span;
    r = $urandom_range(0, 99);
    if (r < 60) delta = lat + OVERHEAD + 1 + $urandom_range(0, 3000);
    else if (r < 75) delta = $urandom_range(0, lat + OVERHEAD);
    else if (r < 85) delta = lat + OVERHEAD - 1 + $urandom_range(0, 2);
    else if (r < 93) begin
      ep.t_start = span - $urandom_range(0, 5000);
      delta = $urandom_range(0, 20000);
    end else delta = $urandom;
    ep.t_end = (ep.t_start + delta) & span;
    if (r >= 95) begin
      ep.t_start = $urandom;
      ep.t_end = $urandom;
    end
    return ep;
  endfunction

  // Write one register and mirror it in the model
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_VALID_MASK: begin
        reg_valid = value[7:0];
        restart_ladder();
      end
      CFG_TYPE_TABLE: begin
        reg_types = value[13:0];
        restart_ladder();
      end
      CFG_MEDIUM_LAT:   reg_med_lat = value[11:0];
      CFG_DEEP_LAT:     reg_deep_lat = value[11:0];
      CFG_MAX_STATE:    reg_max = value[3:0];
      CFG_HISTORY_MASK: reg_hmask = value;
      CFG_WIDE_TIMER:   reg_wide = value[0];
      CFG_BM_CHECK:     reg_bm_on = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_ladder(logic [7:0] vm, logic [13:0] tt, logic [11:0] med,
                                logic [11:0] deep, logic [3:0] mx, logic [31:0] hm,
                                logic wide, logic bm_on);
    write_reg(CFG_VALID_MASK, 32'(vm));
    write_reg(CFG_TYPE_TABLE, 32'(tt));
    write_reg(CFG_MEDIUM_LAT, 32'(med));
    write_reg(CFG_DEEP_LAT, 32'(deep));
    write_reg(CFG_MAX_STATE, 32'(mx));
    write_reg(CFG_HISTORY_MASK, hm);
    write_reg(CFG_WIDE_TIMER, 32'(wide));
    write_reg(CFG_BM_CHECK, 32'(bm_on));
    settings_count++;
  endtask

  task automatic queue_episode(episode_t ep);
    episode_queue.push_back(ep);
    episodes_queued++;
  endtask

  // Wait until every queued episode has its decision checked
  task automatic drain();
    while (decisions_checked < episodes_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: offer queued episodes, hold while stalled, predict on acceptance
  always @(posedge clk) begin : driver
    int gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_moves.push_back(govern_episode(on_offer));
        episodes_sent++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (episode_queue.size() > 0) begin
        on_offer = episode_queue.pop_front();
        s_tdata <= {1'b0, on_offer};
        s_tvalid <= 1'b1;
        gap_left = pick_gap((episodes_sent / 150) % 3 == 2);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each decision, stall the output at random
  always @(posedge clk) begin : monitor
    result_t want, got;
    int      hold_left, h;
    bit      squeezed;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      squeezed = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (predicted_moves.size() == 0) begin
          $error("decision with nothing pending: %h", m_tdata);
          errors++;
        end else begin
          want = predicted_moves.pop_front();
          if (got.next_index !== want.next_index) begin
            $error("next_index: expected %0d, got %0d", want.next_index, got.next_index);
            errors++;
          end
          if (got.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, got.changed);
            errors++;
          end
          if (got.slept !== want.slept) begin
            $error("slept: expected %0d, got %0d", want.slept, got.slept);
            errors++;
          end
          if (got.reload_action !== want.reload_action) begin
            $error("reload_action: expected %0d, got %0d",
                   want.reload_action, got.reload_action);
            errors++;
          end
          if (got.clear_status !== want.clear_status) begin
            $error("clear_status: expected %0d, got %0d",
                   want.clear_status, got.clear_status);
            errors++;
          end
        end
        decisions_checked++;
      end
      // One long hold-off mid-run so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!squeezed && decisions_checked >= 250) begin
        squeezed = 1'b1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else begin
        h = pick_gap((decisions_checked / 200) % 3 == 1);
        if (h == 0) begin
          m_tready <= 1'b1;
        end else begin
          hold_left = h - 1;
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Stimulus: directed episodes, then random phases under varied settings
  initial begin : stimulus
    logic [7:0]  vm;
    logic [13:0] tt;
    logic [11:0] med, deep;
    logic [3:0]  mx;
    logic [31:0] hm;
    logic        bm_on;
    int          r;
    reg_valid = VALID_MASK_RESET;
    reg_types = '0;
    reg_med_lat = '0;
    reg_deep_lat = '0;
    reg_max = MAX_STATE_RESET;
    reg_hmask = HISTORY_MASK_RESET;
    reg_wide = 1'b0;
    reg_bm_on = 1'b0;
    busy_hist = '0;
    restart_ladder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one rung of type zero, bus-master tracking off
    queue_episode(episode_of(0, 0, 32'h0, 32'h0));
    queue_episode(episode_of(32, 1, 32'hFFFF_FFFF, 32'h0));
    queue_episode(episode_of(63, 1, 32'h0, 32'hFFFF_FFFF));
    drain();

    // Full ladder: shallow, medium, deep, type zero, medium, deep, deep
    program_ladder(8'hFE, 14'd15929, 12'd100, 12'd4095, 4'd8, 32'h1, 1'b0, 1'b1);
    queue_episode(episode_of(0, 0, 32'h0, 32'h0));
    queue_episode(episode_of(1, 1, 32'hFFFF_FFFF, 32'h0));
    queue_episode(episode_of(2, 0, 32'h0, 32'hFFFF_FFFF));
    queue_episode(episode_of(32, 1, 32'h1234, 32'h5678));
    queue_episode(episode_of(63, 0, 32'h0, 32'h0));
    queue_episode(episode_of(5, 1, 32'h10, 32'h5));
    queue_episode(episode_of(0, 0, 32'h0, 32'h0));
    queue_episode(episode_of(0, 0, 32'h0, 32'h0));
    queue_episode(episode_of(0, 0, 32'h0, 32'h0));
    queue_episode(episode_of(1, 0, 32'h0, 32'h0));
    // Medium rung: four sleeps below its exit latency; the first drops back to the shallow rung
    for (int i = 0; i < 4; i++) queue_episode(episode_of(0, 0, 32'd1000, 32'd1200));
    // Bus-master activity on the shallow rung: no early drop, which needs a deep rung
    queue_episode(episode_of(0, 1, 32'd0, 32'd9000));
    // 24-bit wrap that still counts as a long sleep
    queue_episode(episode_of(0, 0, 32'h00FF_FF00, 32'h0000_0100));
    drain();

    // Wide timer and a lowered ceiling: 32-bit wrap and a ceiling that stops the climb
    write_reg(CFG_WIDE_TIMER, 32'd1);
    write_reg(CFG_MAX_STATE, 32'd1);
    queue_episode(episode_of(0, 0, 32'hFFFF_FFF0, 32'h0000_0010));
    queue_episode(episode_of(3, 1, 32'hFFFF_FF00, 32'h0000_0300));
    drain();

    // No usable rung at all
    write_reg(CFG_VALID_MASK, 32'h0);
    queue_episode(episode_of(32, 1, 32'h0, 32'hFFFF_FFFF));
    queue_episode(episode_of(0, 0, 32'hFFFF_FFFF, 32'h0));
    drain();

    for (int p = 0; p < 9; p++) begin
      r = $urandom_range(0, 2);
      case (p)
        0: vm = 8'hFE;
        1: vm = 8'hFF;
        2: vm = 8'(1 << $urandom_range(1, 7));
        default: vm = 8'($urandom_range(0, 255));
      endcase
      tt = (p == 0) ? 14'h0000 : (p == 1) ? 14'h3FFF : 14'($urandom_range(0, 16383));
      med = (p == 0) ? 12'd0 : (p == 1) ? 12'd4095 : 12'($urandom_range(0, 600));
      deep = (p == 0) ? 12'd0 : (p == 1) ? 12'd4095 : 12'($urandom_range(0, 600));
      mx = (p == 0) ? 4'd0 : (p == 1) ? 4'd8 : (p == 3) ? 4'd15 : 4'($urandom_range(1, 8));
      if (p == 0) hm = 32'h0;
      else if (p == 1) hm = 32'hFFFF_FFFF;
      else if (r == 0) hm = 32'h0;
      else if (r == 1) hm = 32'h1 << $urandom_range(0, 31);
      else hm = $urandom;
      bm_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      program_ladder(vm, tt, med, deep, mx, hm, 1'(p % 2), bm_on);
      for (int i = 0; i < 100; i++) queue_episode(random_episode());
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d idle episodes over %0d full ladder settings and extra writes",
             decisions_checked, settings_count);
    $display("Model saw %0d rung moves, %0d of them early bus-master demotions",
             state_moves, early_demotions);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up if the block stops making progress
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
